@@ src/one_wire_pulse_width_byte_sender_core_macros.svh @@
// Assertion macros for the pulse-width byte sender checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ONE_WIRE_PULSE_WIDTH_BYTE_SENDER_CORE_MACROS_SVH
`define ONE_WIRE_PULSE_WIDTH_BYTE_SENDER_CORE_MACROS_SVH

// same-cycle implication
`define OWPBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OWPBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/owpbs_pkg.sv @@
// Shared types and constants of the pulse-width byte sender.
// No dependencies.
`default_nettype none

package owpbs_pkg;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_START_HIGH = 2'd0;
    localparam logic [1:0] REG_START_LOW  = 2'd1;
    localparam logic [1:0] REG_LONG       = 2'd2;
    localparam logic [1:0] REG_SHORT      = 2'd3;

    localparam logic [TIME_W-1:0] RST_START_HIGH = 16'd100;
    localparam logic [TIME_W-1:0] RST_START_LOW  = 16'd3000;
    localparam logic [TIME_W-1:0] RST_LONG       = 16'd1500;
    localparam logic [TIME_W-1:0] RST_SHORT      = 16'd500;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] start_high;
        logic [TIME_W-1:0] start_low;
        logic [TIME_W-1:0] long_t;
        logic [TIME_W-1:0] short_t;
    } t_cfg;

endpackage

`default_nettype wire

@@ src/owpbs_regs.sv @@
// APB register file holding the four phase durations.
// Depends on owpbs_pkg.
`default_nettype none

module owpbs_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owpbs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [owpbs_pkg::PDATA_W-1:0] pwdata,
    output logic      [owpbs_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output owpbs_pkg::t_cfg                    o_cfg
);
    import owpbs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_high <= RST_START_HIGH;
            r_cfg.start_low  <= RST_START_LOW;
            r_cfg.long_t     <= RST_LONG;
            r_cfg.short_t    <= RST_SHORT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_HIGH: r_cfg.start_high <= pwdata[TIME_W-1:0];
                REG_START_LOW:  r_cfg.start_low  <= pwdata[TIME_W-1:0];
                REG_LONG:       r_cfg.long_t     <= pwdata[TIME_W-1:0];
                REG_SHORT:      r_cfg.short_t    <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_HIGH: prdata = {{(PDATA_W-TIME_W){1'b0}}, r_cfg.start_high};
            REG_START_LOW:  prdata = {{(PDATA_W-TIME_W){1'b0}}, r_cfg.start_low};
            REG_LONG:       prdata = {{(PDATA_W-TIME_W){1'b0}}, r_cfg.long_t};
            REG_SHORT:      prdata = {{(PDATA_W-TIME_W){1'b0}}, r_cfg.short_t};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/one_wire_pulse_width_byte_sender_core.sv @@
// Top level of the single-wire pulse-width byte sender.
// Depends on owpbs_pkg and owpbs_regs.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | to core   | i_in_valid / o_in_stall  | i_command, i_data_byte
//  out     | from core | o_out_valid / i_out_stall| line, busy, done, rejected
//  cfg     | to core   | APB psel/penable/pwrite  | pwdata, paddr, prdata
//
// One word per cycle while o_in_stall is low: the phase counter update is a
// single pass from the state registers into the result register, and a word's
// result shows in the next cycle. o_in_stall is high only while a result is
// held and i_out_stall is high. Synchronous active-low reset: line high, idle.
`default_nettype none

module one_wire_pulse_width_byte_sender_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_command,
    input  wire logic [owpbs_pkg::DATA_W-1:0]  i_data_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_line_level,
    output logic                               o_busy_res,
    output logic                               o_frame_done,
    output logic                               o_rejected,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owpbs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [owpbs_pkg::PDATA_W-1:0] pwdata,
    output logic      [owpbs_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);
    import owpbs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_HIGH = 3'd1,
        PH_START_LOW  = 3'd2,
        PH_CELL_HIGH  = 3'd3,
        PH_CELL_LOW   = 3'd4
    } t_phase;

    t_cfg cfg;

    owpbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    t_phase              r_phase, n_phase;
    logic [2:0]          r_bit_index, n_bit_index;
    logic [DATA_W-1:0]   r_shift_byte, n_shift_byte;
    logic [TIME_W-1:0]   r_time_left, n_time_left;
    logic                r_wire_level, n_wire_level;
    logic                r_out_valid, r_busy, r_done, r_rej;
    logic                res_done, res_rej;
    logic [TIME_W-1:0]   tl_dec;
    logic                accept;

    assign o_in_stall   = r_out_valid & i_out_stall;
    assign accept       = i_in_valid & ~o_in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_wire_level;
    assign o_busy_res   = r_busy;
    assign o_frame_done = r_done;
    assign o_rejected   = r_rej;

    assign tl_dec = (r_time_left != '0) ? r_time_left - TIME_W'(1) : '0;

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_time_left  = r_time_left;
        n_wire_level = r_wire_level;
        res_done     = 1'b0;
        res_rej      = 1'b0;
        if (i_command == CMD_SEND) begin
            if (r_phase != PH_IDLE) begin
                res_rej = 1'b1;
            end else begin
                n_shift_byte = i_data_byte;
                n_bit_index  = '0;
                n_phase      = PH_START_HIGH;
                n_wire_level = 1'b1;
                n_time_left  = at_least_one(cfg.start_high);
            end
        end else if (r_phase != PH_IDLE) begin
            n_time_left = tl_dec;
            if (tl_dec == '0) begin
                unique case (r_phase)
                    PH_START_HIGH: begin
                        n_phase      = PH_START_LOW;
                        n_wire_level = 1'b0;
                        n_time_left  = at_least_one(cfg.start_low);
                    end
                    PH_START_LOW: begin
                        n_phase      = PH_CELL_HIGH;
                        n_wire_level = 1'b1;
                        n_time_left  = at_least_one(r_shift_byte[0] ? cfg.long_t
                                                                    : cfg.short_t);
                    end
                    PH_CELL_HIGH: begin
                        n_phase      = PH_CELL_LOW;
                        n_wire_level = 1'b0;
                        n_time_left  = at_least_one(r_shift_byte[0] ? cfg.short_t
                                                                    : cfg.long_t);
                    end
                    PH_CELL_LOW: begin
                        n_shift_byte = r_shift_byte >> 1;
                        n_wire_level = 1'b1;
                        if (r_bit_index == 3'd7) begin
                            n_bit_index = '0;
                            n_phase     = PH_IDLE;
                            res_done    = 1'b1;
                        end else begin
                            n_bit_index = r_bit_index + 3'd1;
                            n_phase     = PH_CELL_HIGH;
                            // next cell keys off the next data bit, bit 1 before the shift
                            n_time_left = at_least_one(r_shift_byte[1] ? cfg.long_t
                                                                       : cfg.short_t);
                        end
                    end
                    default: begin
                        n_phase      = PH_IDLE;
                        n_wire_level = 1'b1;
                        n_time_left  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
            r_time_left  <= '0;
            r_wire_level <= 1'b1;
            r_out_valid  <= 1'b0;
            r_busy       <= 1'b0;
            r_done       <= 1'b0;
            r_rej        <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_bit_index  <= n_bit_index;
                r_shift_byte <= n_shift_byte;
                r_time_left  <= n_time_left;
                r_wire_level <= n_wire_level;
                r_busy       <= (n_phase != PH_IDLE);
                r_done       <= res_done;
                r_rej        <= res_rej;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/owpbs_checker.sv @@
// Port-level checker for the pulse-width byte sender, bound to the top level.
// Depends on the assertion macros header.
`default_nettype none
`include "one_wire_pulse_width_byte_sender_core_macros.svh"

module owpbs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_line_level,
    input wire logic        o_busy_res,
    input wire logic        o_frame_done,
    input wire logic        o_rejected
);

    `OWPBS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `OWPBS_ASSERT_NEXT(a_word_out, i_in_valid && !o_in_stall, o_out_valid, "accepted word gave no result")
    `OWPBS_ASSERT_NOW(a_idle_high, o_out_valid && !o_busy_res, o_line_level, "line low while idle")
    `OWPBS_ASSERT_NOW(a_done_idle, o_out_valid && o_frame_done, !o_busy_res && !o_rejected, "frame end while busy")
    `OWPBS_ASSERT_NOW(a_rej_busy, o_out_valid && o_rejected, o_busy_res, "reject while idle")

endmodule

bind one_wire_pulse_width_byte_sender_core owpbs_checker u_owpbs_checker (.*);

`default_nettype wire

@@ tb/sv/one_wire_pulse_width_byte_sender_core_tb.sv @@
// Self-checking testbench for one_wire_pulse_width_byte_sender_core.
// Depends on owpbs_pkg; drives random tick/send words through APB-set timings
// and checks every result word against a built-in cycle-free predictor.
`default_nettype none

module one_wire_pulse_width_byte_sender_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owpbs_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 150;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_HIGH,
        PH_START_LOW,
        PH_CELL_HIGH,
        PH_CELL_LOW
    } t_wire_phase;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic frame_done;
        logic rejected;
    } t_line_status;

    class t_line_status_scoreboard;
        t_cfg               timing;
        t_wire_phase        phase;
        logic [2:0]         bit_idx;
        logic [7:0]         shifter;
        logic [TIME_W-1:0]  remaining;
        logic               level;
        t_line_status       pending_status[$];
        int                 mismatches;
        int                 words_checked;
        int                 frames_done;
        int                 sends_rejected;

        function new();
            timing = {RST_START_HIGH, RST_START_LOW, RST_LONG, RST_SHORT};
            phase = PH_IDLE;
            bit_idx = '0;
            shifter = '0;
            remaining = '0;
            level = 1'b1;
            mismatches = 0;
            words_checked = 0;
            frames_done = 0;
            sends_rejected = 0;
        endfunction

        function logic [TIME_W-1:0] ticks_of(logic [TIME_W-1:0] v);
            return (v == '0) ? TIME_W'(1) : v;
        endfunction

        function void begin_cell();
            phase = PH_CELL_HIGH;
            level = 1'b1;
            remaining = ticks_of(shifter[0] ? timing.long_t : timing.short_t);
        endfunction

        function void set_reg(logic [1:0] idx, logic [TIME_W-1:0] v);
            case (idx)
                REG_START_HIGH: timing.start_high = v;
                REG_START_LOW:  timing.start_low = v;
                REG_LONG:       timing.long_t = v;
                REG_SHORT:      timing.short_t = v;
                default: ;
            endcase
        endfunction

        function bit is_busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        function void take_word(logic cmd, logic [7:0] data);
            t_line_status r;
            r = '0;
            if (cmd == CMD_SEND) begin
                if (phase != PH_IDLE) begin
                    r.rejected = 1'b1;
                    sends_rejected++;
                end else begin
                    shifter = data;
                    bit_idx = '0;
                    phase = PH_START_HIGH;
                    level = 1'b1;
                    remaining = ticks_of(timing.start_high);
                end
            end else if (phase != PH_IDLE) begin
                if (remaining != '0) remaining = remaining - 1'b1;
                if (remaining == '0) begin
                    case (phase)
                        PH_START_HIGH: begin
                            phase = PH_START_LOW;
                            level = 1'b0;
                            remaining = ticks_of(timing.start_low);
                        end
                        PH_START_LOW: begin
                            begin_cell();
                        end
                        PH_CELL_HIGH: begin
                            phase = PH_CELL_LOW;
                            level = 1'b0;
                            remaining = ticks_of(shifter[0] ? timing.short_t : timing.long_t);
                        end
                        PH_CELL_LOW: begin
                            shifter = shifter >> 1;
                            if (bit_idx == 3'd7) begin
                                bit_idx = '0;
                                phase = PH_IDLE;
                                level = 1'b1;
                                r.frame_done = 1'b1;
                                frames_done++;
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                                begin_cell();
                            end
                        end
                        default: begin
                            phase = PH_IDLE;
                            level = 1'b1;
                            remaining = '0;
                        end
                    endcase
                end
            end
            r.line_level = level;
            r.busy = (phase != PH_IDLE);
            pending_status.push_back(r);
        endfunction

        function void check_word(t_line_status got);
            t_line_status want;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: line=%b busy=%b done=%b rej=%b",
                             $realtime, got.line_level, got.busy, got.frame_done,
                             got.rejected);
                return;
            end
            want = pending_status.pop_front();
            words_checked++;
            if (got.line_level !== want.line_level || got.busy !== want.busy ||
                got.frame_done !== want.frame_done || got.rejected !== want.rejected) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] word %0d: exp line/busy/done/rej=%b%b%b%b got %b%b%b%b",
                             $realtime, words_checked, want.line_level, want.busy,
                             want.frame_done, want.rejected, got.line_level, got.busy,
                             got.frame_done, got.rejected);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_command;
    logic [DATA_W-1:0]   i_data_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_line_level;
    logic                o_busy_res;
    logic                o_frame_done;
    logic                o_rejected;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    t_line_status_scoreboard model;
    int send_idle_pct;
    int stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int cycles;

    one_wire_pulse_width_byte_sender_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done),
        .o_rejected   (o_rejected),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output back-pressure; a long hold is served on request
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            model.check_word({o_line_level, o_busy_res, o_frame_done, o_rejected});
    end

    task automatic send_word(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model.take_word(cmd, data);
    endtask

    task automatic run_words(input int count);
        logic       cmd;
        logic [7:0] data;
        int         pick;
        for (int k = 0; k < count; k++) begin
            if (model.is_busy())
                cmd = ($urandom_range(99) < 6) ? CMD_SEND : CMD_TICK;
            else
                cmd = ($urandom_range(99) < 60) ? CMD_SEND : CMD_TICK;
            pick = $urandom_range(9);
            data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            send_word(cmd, data);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [TIME_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {{(PDATA_W-TIME_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        model.set_reg(reg_idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_timing(input logic [TIME_W-1:0] sh, input logic [TIME_W-1:0] sl,
                                  input logic [TIME_W-1:0] lg, input logic [TIME_W-1:0] st);
        drain_results();
        apb_write(REG_START_HIGH, sh);
        apb_write(REG_START_LOW, sl);
        apb_write(REG_LONG, lg);
        apb_write(REG_SHORT, st);
    endtask

    initial begin
        model = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = CMD_TICK;
        i_data_byte = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;
        cycles = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timings: idle tick, a send, then sends while busy
        send_word(CMD_TICK, 8'hFF);
        send_word(CMD_SEND, 8'hA5);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_SEND, 8'hFF);
        send_word(CMD_SEND, 8'h00);

        // zero timings act as one tick; written mid-frame
        program_timing('0, '0, '0, '0);
        run_words(60);
        hold_requests = hold_requests + 1;
        run_words(120);

        send_idle_pct = 81;
        program_timing(TIME_W'($urandom_range(1, 5)), TIME_W'($urandom_range(1, 5)),
                       TIME_W'($urandom_range(1, 5)), TIME_W'($urandom_range(1, 5)));
        run_words(180);

        send_idle_pct = 0;
        stall_pct = 81;
        program_timing(16'd1, TIME_W'($urandom_range(0, 6)),
                       16'd0, TIME_W'($urandom_range(1, 6)));
        run_words(180);

        send_idle_pct = 38;
        stall_pct = 38;
        program_timing(TIME_W'($urandom_range(1, 4)), TIME_W'($urandom_range(1, 4)),
                       TIME_W'($urandom_range(1, 4)), TIME_W'($urandom_range(1, 4)));
        run_words(180);

        send_idle_pct = 0;
        stall_pct = 0;
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_words(30);

        drain_results();
        $display("Checked %0d result words, %0d frames completed, %0d sends turned away.",
                 model.words_checked, model.frames_done, model.sends_rejected);
        $display("Timings from zero to full scale, four idle/stall mixes, one long output hold.");
        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", model.mismatches, model.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
